>>> rtl/core/cst_pkg.sv
// Shared types, constants and helpers for the chained symbol table.
// Used by chained_symbol_table_top; depends on nothing else.
package cst_pkg;

    localparam int TABLE_DEPTH    = 512;
    localparam int OVERFLOW_START = 256;
    localparam int BASE_TYPES     = 4;

    localparam int SLOT_W = $clog2(TABLE_DEPTH);
    localparam int HOME_W = $clog2(OVERFLOW_START);
    localparam int STEP_W = SLOT_W + 1;
    localparam int FILL_W = SLOT_W + 1;

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_LOOKUP = 1'b1;

    localparam logic [2:0] KIND_STRUCT    = 3'd0;
    localparam logic [2:0] KIND_ARRAY     = 3'd1;
    localparam logic [2:0] KIND_VARIABLE  = 3'd2;
    localparam logic [2:0] KIND_PROCEDURE = 3'd3;
    localparam logic [2:0] KIND_FUNCTION  = 3'd4;
    localparam logic [2:0] KIND_BASE      = 3'd5;
    localparam logic [2:0] KIND_EMPTY     = 3'd7;

    localparam logic [1:0] STATUS_OK        = 2'd0;
    localparam logic [1:0] STATUS_FULL      = 2'd1;
    localparam logic [1:0] STATUS_NOT_FOUND = 2'd2;

    localparam logic [12:0] DESC_NONE = 13'h1000;
    localparam logic [16:0] EXEC_NONE = 17'h10000;
    localparam logic [16:0] EXEC_ONE  = 17'd1;

    typedef struct packed {
        logic        op;
        logic [2:0]  kind;
        logic [7:0]  name_index;
        logic [7:0]  region;
        logic [11:0] description;
        logic [15:0] exec_value;
    } t_in_item;

    typedef struct packed {
        logic [1:0] status;
        logic [8:0] slot;
    } t_out_item;

    typedef struct packed {
        logic [2:0]        kind;
        logic [7:0]        region;
        logic              nxt_vld;
        logic [SLOT_W-1:0] nxt;
        logic [12:0]       desc;
        logic [16:0]       exec;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // Contents of a slot that has not been written since reset.
    function automatic t_entry reset_entry(input logic [SLOT_W-1:0] slot);
        t_entry e;
        e.kind    = (32'(slot) < BASE_TYPES) ? KIND_BASE : KIND_EMPTY;
        e.region  = 8'd0;
        e.nxt_vld = 1'b0;
        e.nxt     = '0;
        e.desc    = DESC_NONE;
        e.exec    = EXEC_NONE;
        return e;
    endfunction

    // A freshly declared entry: no successor yet.
    function automatic t_entry make_entry(input t_in_item item);
        t_entry e;
        e.kind    = item.kind;
        e.region  = item.region;
        e.nxt_vld = 1'b0;
        e.nxt     = '0;
        e.desc    = {1'b0, item.description};
        case (item.kind)
            KIND_VARIABLE:                  e.exec = EXEC_ONE;
            KIND_PROCEDURE, KIND_FUNCTION:  e.exec = {1'b0, item.exec_value};
            default:                        e.exec = EXEC_NONE;
        endcase
        return e;
    endfunction

endpackage

>>> rtl/core/cst_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies; one write or one read address per cycle.
module cst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/core/chained_symbol_table_top.sv
// States: rejected, S_DONE; lookup, S_READ and S_CHECK per chain entry visited, then S_DONE
// (a full table on insert is seen at the first entry); insert into an empty home slot, S_READ,
// S_CHECK, S_WR_HOME, S_DONE; insert behind a chain, S_READ and S_CHECK per entry walked, then
// S_WR_TAIL, S_WR_NEW, S_DONE. One transaction at a time: the input stalls until the result
// enters the output register and accepts again in the next cycle at the earliest.
// Reset clears the sequencer, the overflow fill counter and the home-slot valid bits at
// once; there is no clearing pass and a transaction is accepted right after reset.
// Depends on cst_pkg and cst_ram.
module chained_symbol_table_top (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_stall,
    input  cst_pkg::t_in_item i_in_data,
    output logic              o_out_valid,
    input  logic              i_out_stall,
    output cst_pkg::t_out_item o_out_data
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_WR_HOME,
        S_WR_TAIL,
        S_WR_NEW,
        S_DONE
    } t_state;

    t_state                         r_state;
    cst_pkg::t_in_item              r_item;
    logic [cst_pkg::SLOT_W-1:0]     r_cur;
    logic [cst_pkg::STEP_W-1:0]     r_steps;
    logic [cst_pkg::FILL_W-1:0]     r_fill;
    cst_pkg::t_entry                r_tail;
    cst_pkg::t_out_item             r_res;
    cst_pkg::t_out_item             r_out;
    logic                           r_out_vld;
    logic [cst_pkg::OVERFLOW_START-1:0] r_home_vld;

    logic                           ram_we;
    logic [cst_pkg::SLOT_W-1:0]     ram_addr;
    cst_pkg::t_entry                ram_wdata;
    logic [cst_pkg::ENTRY_W-1:0]    ram_rdata;
    cst_pkg::t_entry                cur_entry;
    logic                           cur_is_home;
    logic                           home_ok;

    cst_ram #(
        .WIDTH (cst_pkg::ENTRY_W),
        .DEPTH (cst_pkg::TABLE_DEPTH)
    ) u_entries (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_addr  (ram_addr),
        .i_wdata (ram_wdata),
        .o_rdata (ram_rdata)
    );

    assign home_ok = (32'(i_in_data.name_index) < cst_pkg::OVERFLOW_START)
                  && (32'(i_in_data.name_index) < cst_pkg::TABLE_DEPTH);

    assign cur_is_home = (32'(r_cur) < cst_pkg::OVERFLOW_START);

    // Overflow slots are read only after they were linked, hence written; a home slot
    // that was never written reads as its reset contents.
    always_comb begin
        if (cur_is_home && !r_home_vld[r_cur[cst_pkg::HOME_W-1:0]]) begin
            cur_entry = cst_pkg::reset_entry(r_cur);
        end else begin
            cur_entry = cst_pkg::t_entry'(ram_rdata);
        end
    end

    always_comb begin
        ram_we    = 1'b0;
        ram_addr  = r_cur;
        ram_wdata = cst_pkg::make_entry(r_item);
        case (r_state)
            S_WR_HOME: begin
                ram_we = 1'b1;
            end
            S_WR_TAIL: begin
                ram_we            = 1'b1;
                ram_wdata         = r_tail;
                ram_wdata.nxt_vld = 1'b1;
                ram_wdata.nxt     = r_fill[cst_pkg::SLOT_W-1:0];
            end
            S_WR_NEW: begin
                ram_we   = 1'b1;
                ram_addr = r_fill[cst_pkg::SLOT_W-1:0];
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_fill     <= cst_pkg::FILL_W'(cst_pkg::OVERFLOW_START);
            r_home_vld <= '0;
        end else begin
            // In S_DONE the load below decides the output valid on its own.
            if (r_out_vld && !i_out_stall && r_state != S_DONE) begin
                r_out_vld <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_item  <= i_in_data;
                        r_cur   <= cst_pkg::SLOT_W'(i_in_data.name_index);
                        r_steps <= '0;
                        if (!home_ok) begin
                            r_res.status <= (i_in_data.op == cst_pkg::OP_LOOKUP)
                                          ? cst_pkg::STATUS_NOT_FOUND : cst_pkg::STATUS_FULL;
                            r_res.slot   <= '0;
                            r_state      <= S_DONE;
                        end else if (i_in_data.op == cst_pkg::OP_INSERT
                                     && i_in_data.kind > cst_pkg::KIND_FUNCTION) begin
                            r_res.status <= cst_pkg::STATUS_FULL;
                            r_res.slot   <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_state <= S_READ;
                        end
                    end
                end
                S_READ: begin
                    r_state <= S_CHECK;
                end
                S_CHECK: begin
                    if (r_item.op == cst_pkg::OP_LOOKUP) begin
                        if (cur_entry.kind == cst_pkg::KIND_EMPTY) begin
                            r_res.status <= cst_pkg::STATUS_NOT_FOUND;
                            r_res.slot   <= '0;
                            r_state      <= S_DONE;
                        end else if (cur_entry.region == r_item.region) begin
                            r_res.status <= cst_pkg::STATUS_OK;
                            r_res.slot   <= 9'(r_cur);
                            r_state      <= S_DONE;
                        end else if (!cur_entry.nxt_vld
                                     || r_steps == cst_pkg::STEP_W'(cst_pkg::TABLE_DEPTH - 1))
                        begin
                            r_res.status <= cst_pkg::STATUS_NOT_FOUND;
                            r_res.slot   <= '0;
                            r_state      <= S_DONE;
                        end else begin
                            r_cur   <= cur_entry.nxt;
                            r_steps <= r_steps + 1'b1;
                            r_state <= S_READ;
                        end
                    end else begin
                        if (cur_entry.kind == cst_pkg::KIND_EMPTY) begin
                            r_state <= S_WR_HOME;
                        end else if (r_fill == cst_pkg::FILL_W'(cst_pkg::TABLE_DEPTH)) begin
                            r_res.status <= cst_pkg::STATUS_FULL;
                            r_res.slot   <= '0;
                            r_state      <= S_DONE;
                        end else if (!cur_entry.nxt_vld
                                     || r_steps == cst_pkg::STEP_W'(cst_pkg::TABLE_DEPTH)) begin
                            r_tail  <= cur_entry;
                            r_state <= S_WR_TAIL;
                        end else begin
                            r_cur   <= cur_entry.nxt;
                            r_steps <= r_steps + 1'b1;
                            r_state <= S_READ;
                        end
                    end
                end
                S_WR_HOME: begin
                    r_home_vld[r_cur[cst_pkg::HOME_W-1:0]] <= 1'b1;
                    r_res.status <= cst_pkg::STATUS_OK;
                    r_res.slot   <= 9'(r_cur);
                    r_state      <= S_DONE;
                end
                S_WR_TAIL: begin
                    if (cur_is_home) begin
                        r_home_vld[r_cur[cst_pkg::HOME_W-1:0]] <= 1'b1;
                    end
                    r_state <= S_WR_NEW;
                end
                S_WR_NEW: begin
                    r_fill       <= r_fill + 1'b1;
                    r_res.status <= cst_pkg::STATUS_OK;
                    r_res.slot   <= 9'(r_fill[cst_pkg::SLOT_W-1:0]);
                    r_state      <= S_DONE;
                end
                S_DONE: begin
                    // The output register takes the result once its previous
                    // transaction has left.
                    if (!r_out_vld || !i_out_stall) begin
                        r_out     <= r_res;
                        r_out_vld <= 1'b1;
                        r_state   <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

endmodule

>>> tb/sv/chained_symbol_table_top_test.sv
`timescale 1ns / 1ps
// Testbench for chained_symbol_table_top: directed declarations and lookups, then random ones,
// checked against a row's given reply or a symbol table predictor kept in this file. Depends on cst_pkg.
module chained_symbol_table_top_test;

    localparam int RANDOM_ITEMS = 1000;
    localparam int IDLE_LIMIT   = 4000;
    localparam int DRAIN_CYCLES = 40;

    // Insert kinds above KIND_FUNCTION are rejected by the table.
    localparam logic [2:0] KIND_BAD = 3'd6;

    typedef struct packed {
        cst_pkg::t_in_item  item;
        logic               typed;
        cst_pkg::t_out_item want;
    } t_stim_row;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    cst_pkg::t_in_item  in_data = '0;
    logic               out_valid;
    logic               out_stall = 1'b1;
    cst_pkg::t_out_item out_data;

    bit        calm = 1'b0;
    int        faults = 0;
    int        idle_cycles = 0;

    // Predicted table contents; description and execution values never reach the outputs.
    logic [2:0] sym_kind    [cst_pkg::TABLE_DEPTH];
    logic [7:0] sym_region  [cst_pkg::TABLE_DEPTH];
    logic       sym_chained [cst_pkg::TABLE_DEPTH];
    int         sym_next    [cst_pkg::TABLE_DEPTH];
    int         overflow_next;

    cst_pkg::t_out_item slot_replies_due[$];
    t_stim_row          stim_rows[$];

    chained_symbol_table_top u_top (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data)
    );

    always #2 clk = ~clk;

    function automatic void claim_slot(input int s, input cst_pkg::t_in_item it);
        sym_kind[s]    = it.kind;
        sym_region[s]  = it.region;
        sym_chained[s] = 1'b0;
        sym_next[s]    = 0;
    endfunction

    // Applies one declaration or lookup to the predicted table and returns its reply.
    function automatic cst_pkg::t_out_item declare_or_find(input cst_pkg::t_in_item it);
        cst_pkg::t_out_item res;
        int        home;
        int        cur;
        int        steps;
        bit        home_ok;
        res.status = cst_pkg::STATUS_OK;
        res.slot   = '0;
        home       = int'(it.name_index);
        home_ok    = (home < cst_pkg::OVERFLOW_START) && (home < cst_pkg::TABLE_DEPTH);
        if (it.op == cst_pkg::OP_LOOKUP) begin
            res.status = cst_pkg::STATUS_NOT_FOUND;
            if (home_ok) begin
                cur = home;
                for (steps = 0; steps < cst_pkg::TABLE_DEPTH; steps++) begin
                    if (sym_kind[cur] == cst_pkg::KIND_EMPTY)
                        break;
                    if (sym_region[cur] == it.region) begin
                        res.status = cst_pkg::STATUS_OK;
                        res.slot   = cur[8:0];
                        break;
                    end
                    if (!sym_chained[cur] || sym_next[cur] >= cst_pkg::TABLE_DEPTH)
                        break;
                    cur = sym_next[cur];
                end
            end
        end else if (!home_ok || it.kind > cst_pkg::KIND_FUNCTION) begin
            res.status = cst_pkg::STATUS_FULL;
        end else if (sym_kind[home] == cst_pkg::KIND_EMPTY) begin
            claim_slot(home, it);
            res.slot = home[8:0];
        end else if (overflow_next >= cst_pkg::TABLE_DEPTH) begin
            res.status = cst_pkg::STATUS_FULL;
        end else begin
            cur = home;
            for (steps = 0; steps < cst_pkg::TABLE_DEPTH; steps++) begin
                if (!sym_chained[cur] || sym_next[cur] >= cst_pkg::TABLE_DEPTH)
                    break;
                cur = sym_next[cur];
            end
            sym_chained[cur] = 1'b1;
            sym_next[cur]    = overflow_next;
            claim_slot(overflow_next, it);
            res.slot         = overflow_next[8:0];
            overflow_next    = overflow_next + 1;
        end
        return res;
    endfunction

    function automatic t_stim_row stim(input logic op, input logic [2:0] kind,
                                       input logic [7:0] name, input logic [7:0] region,
                                       input logic [11:0] desc, input logic [15:0] exec,
                                       input logic typed, input logic [1:0] status,
                                       input logic [8:0] slot);
        t_stim_row r;
        r.item.op          = op;
        r.item.kind        = kind;
        r.item.name_index  = name;
        r.item.region      = region;
        r.item.description = desc;
        r.item.exec_value  = exec;
        r.typed            = typed;
        r.want.status      = status;
        r.want.slot        = slot;
        return r;
    endfunction

    // Most traffic lands on a few names and regions so chains grow and lookups hit.
    function automatic cst_pkg::t_in_item random_decl();
        cst_pkg::t_in_item it;
        it.op          = ($urandom_range(0, 9) < 4) ? cst_pkg::OP_LOOKUP : cst_pkg::OP_INSERT;
        it.kind        = ($urandom_range(0, 7) == 0) ? 3'($urandom_range(5, 7))
                                                     : 3'($urandom_range(0, 4));
        it.name_index  = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 15));
        it.region      = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        it.description = 12'($urandom);
        it.exec_value  = 16'($urandom);
        return it;
    endfunction

    task automatic offer_decl(input cst_pkg::t_in_item it, input logic typed,
                              input cst_pkg::t_out_item want);
        int                 gap;
        cst_pkg::t_out_item got;
        gap = calm ? 0 : $urandom_range(0, 4);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        got = declare_or_find(it);
        slot_replies_due.push_back(typed ? want : got);
    endtask

    initial begin
        int i;
        int n;
        for (i = 0; i < cst_pkg::TABLE_DEPTH; i++) begin
            sym_kind[i]    = (i < cst_pkg::BASE_TYPES) ? cst_pkg::KIND_BASE
                                                       : cst_pkg::KIND_EMPTY;
            sym_region[i]  = 8'd0;
            sym_chained[i] = 1'b0;
            sym_next[i]    = 0;
        end
        overflow_next = cst_pkg::OVERFLOW_START;

        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd0, 8'd0,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd3, 8'd5,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_NOT_FOUND, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd4, 8'd0,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_NOT_FOUND, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_EMPTY, 8'd10, 8'd1,
                                 12'h123, 16'h4567, 1'b1, cst_pkg::STATUS_FULL, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_BASE, 8'd10, 8'd1,
                                 12'h123, 16'h4567, 1'b1, cst_pkg::STATUS_FULL, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_STRUCT, 8'd10, 8'd1,
                                 12'h001, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd10));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_ARRAY, 8'd10, 8'd2,
                                 12'h002, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd256));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_VARIABLE, 8'd10, 8'd3,
                                 12'h003, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd257));
        // A name that collides with a base type chains into the overflow area.
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_PROCEDURE, 8'd0, 8'd7,
                                 12'h000, 16'hFFFF, 1'b1, cst_pkg::STATUS_OK, 9'd258));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_FUNCTION, 8'd255, 8'd255,
                                 12'hFFF, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd255));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd10, 8'd3,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd257));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd10, 8'd9,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_NOT_FOUND, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd0, 8'd7,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd258));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd255, 8'd255,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd255));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, KIND_BAD, 8'd255, 8'd0,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_FULL, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_EMPTY, 8'd10, 8'd1,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_OK, 9'd10));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_FUNCTION, 8'd3, 8'd0,
                                 12'h0, 16'h1234, 1'b0, cst_pkg::STATUS_OK, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd3, 8'd0,
                                 12'h0, 16'h0, 1'b0, cst_pkg::STATUS_OK, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_VARIABLE, 8'd255, 8'd255,
                                 12'hABC, 16'h0, 1'b0, cst_pkg::STATUS_OK, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd255, 8'd255,
                                 12'h0, 16'h0, 1'b0, cst_pkg::STATUS_OK, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_INSERT, cst_pkg::KIND_STRUCT, 8'd128, 8'd0,
                                 12'hFFF, 16'hFFFF, 1'b0, cst_pkg::STATUS_OK, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_EMPTY, 8'd255, 8'd255,
                                 12'hFFF, 16'hFFFF, 1'b0, cst_pkg::STATUS_OK, 9'd0));
        stim_rows.push_back(stim(cst_pkg::OP_LOOKUP, cst_pkg::KIND_STRUCT, 8'd0, 8'd255,
                                 12'h0, 16'h0, 1'b1, cst_pkg::STATUS_NOT_FOUND, 9'd0));

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < stim_rows.size(); i++)
            offer_decl(stim_rows[i].item, stim_rows[i].typed, stim_rows[i].want);

        // Random traffic; the home names overflow the chain area about halfway through,
        // after which inserts behind a chain are refused.
        for (n = 0; n < RANDOM_ITEMS; n++) begin
            calm = (n % 128) < 20;
            if (n % 250 == 125) begin
                in_valid <= 1'b0;
                do @(posedge clk); while (slot_replies_due.size() != 0);
            end
            offer_decl(random_decl(), 1'b0, '0);
        end

        in_valid <= 1'b0;
        do @(posedge clk); while (slot_replies_due.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (faults == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    initial begin
        int n;
        wait (rst_n);
        forever begin
            n = calm ? 0 : $urandom_range(0, 4);
            if (n > 0) begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            out_stall <= 1'b0;
            do @(posedge clk); while (!out_valid);
        end
    end

    always @(posedge clk) begin : check_reply
        cst_pkg::t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (slot_replies_due.size() == 0) begin
                $error("result with nothing outstanding: status %0d slot %0d",
                       out_data.status, out_data.slot);
                faults++;
            end else begin
                want = slot_replies_due.pop_front();
                if (out_data.status !== want.status) begin
                    $error("status: expected %0d, got %0d", want.status, out_data.status);
                    faults++;
                end
                if (out_data.slot !== want.slot) begin
                    $error("slot: expected %0d, got %0d", want.slot, out_data.slot);
                    faults++;
                end
            end
        end
    end

    // Ends a run in which no transaction moves on either channel for too long.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("RESULT: ERROR");
                $finish;
            end
        end
    end

endmodule
